>>> sv/rasmr_pkg.sv
// Package for the rational add/subtract/multiply block: widths, codes, queue entry type.
// No dependencies.
package rasmr_pkg;
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int RES_W = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_MUL_ALT = 2'd3
    } op_t;

    // raw fraction handed from front to back
    typedef struct packed {
        logic [RES_W-1:0] num;
        logic [RES_W-1:0] den;
        logic             err;
    } raw_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GCD,
        BK_DIVN,
        BK_DIVD,
        BK_DONE
    } bk_state_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL1,
        FR_MUL2,
        FR_PUSH
    } fr_state_t;
endpackage

>>> sv/rasmr_if.sv
// Valid/ready channel interfaces for requests and results.
// No dependencies.
interface rasmr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rasmr_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] res_num;
    logic [63:0] res_den;
    logic        status;
    modport source (output valid, res_num, res_den, status, input ready);
    modport sink (input valid, res_num, res_den, status, output ready);
endinterface

>>> sv/rational_add_sub_mul_reduce.sv
// Rational add/subtract/multiply with gcd reduction to lowest terms.
// Short path (error, zero numerator or denominator, equal terms) skips gcd and division;
// otherwise a binary gcd, then division of numerator and denominator by the gcd.
// Each end handles one item at a time; the front end holds its item while the queue is full.
// Front and back run concurrently through a two-entry queue.
// Reset: asynchronous active-low rst_n clears all control state; queue empties.
// Depends on rasmr_pkg, rasmr_if, rasmr_front, rasmr_queue, rasmr_back.
module rational_add_sub_mul_reduce #(
    parameter int OPERAND_WIDTH = rasmr_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rasmr_req_if.sink    req,
    rasmr_res_if.source  res
);
    logic            push, full, pop, nonempty;
    rasmr_pkg::raw_t push_data, pop_data;

    rasmr_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .push(push), .push_data(push_data), .full(full)
    );

    rasmr_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
        .pop(pop), .nonempty(nonempty), .pop_data(pop_data)
    );

    rasmr_back u_back (
        .clk(clk), .rst_n(rst_n), .nonempty(nonempty), .pop_data(pop_data),
        .pop(pop), .res(res)
    );
endmodule

>>> sv/rasmr_front.sv
// Front end: accept a request, sign-extend operands, form the raw fraction.
// Depends on rasmr_pkg and rasmr_if; one 32x32 multiplier shared over states MUL1 and MUL2 plus
// a second one for the cross-multiplied denominator.
module rasmr_front #(
    parameter int OPERAND_WIDTH = rasmr_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    rasmr_req_if.sink           req,
    output logic                push,
    output rasmr_pkg::raw_t     push_data,
    input  logic                full
);
    localparam int W = rasmr_pkg::RES_W;

    rasmr_pkg::fr_state_t state_reg, state_next;
    logic [1:0]   op_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0] p1_reg, p2_reg, den_reg;
    logic         eq_reg, err_reg;
    logic [W-1:0] ma, mb, prod, num_sum;

    function automatic logic [W-1:0] sext(input logic [31:0] v);
        return {{(W-OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v[OPERAND_WIDTH-1:0]};
    endfunction

    assign req.ready = (state_reg == rasmr_pkg::FR_IDLE);
    assign push      = (state_reg == rasmr_pkg::FR_PUSH) && !full;
    assign push_data = {num_sum, den_reg, err_reg};

    // shared multiplier: low 32 bits of each sign-extended operand suffice mod 2^64
    always_comb
    begin
        ma = an_reg;
        mb = bn_reg;
        if (state_reg == rasmr_pkg::FR_MUL1)
        begin
            ma = op_reg[1] ? an_reg : an_reg;
            mb = op_reg[1] ? bn_reg : bd_reg;
        end
        else
        begin
            ma = ad_reg;
            mb = op_reg[1] ? bd_reg : bn_reg;
        end
        prod = W'($signed(ma[31:0]) * $signed(mb[31:0]));
    end

    // combine the registered products, or the operands for equal denominators, into the raw numerator
    always_comb
    begin
        if (op_reg[1])
            num_sum = p1_reg;
        else if (eq_reg)
            num_sum = (op_reg == rasmr_pkg::OP_SUB) ? an_reg - bn_reg : an_reg + bn_reg;
        else
            num_sum = (op_reg == rasmr_pkg::OP_SUB) ? p1_reg - p2_reg : p1_reg + p2_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rasmr_pkg::FR_IDLE: if (req.valid) state_next = rasmr_pkg::FR_MUL1;
            rasmr_pkg::FR_MUL1: state_next = rasmr_pkg::FR_MUL2;
            rasmr_pkg::FR_MUL2: state_next = rasmr_pkg::FR_PUSH;
            rasmr_pkg::FR_PUSH: if (!full) state_next = rasmr_pkg::FR_IDLE;
            default:            state_next = rasmr_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rasmr_pkg::FR_IDLE;
        else
            state_reg <= state_next;
    end

    // capture operands, products and the raw denominator
    always_ff @(posedge clk)
    begin
        if (state_reg == rasmr_pkg::FR_IDLE && req.valid)
        begin
            op_reg <= req.req_type;
            an_reg <= sext(req.a_num);
            ad_reg <= sext(req.a_den);
            bn_reg <= sext(req.b_num);
            bd_reg <= sext(req.b_den);
        end
        if (state_reg == rasmr_pkg::FR_MUL1)
        begin
            p1_reg <= prod;
            eq_reg <= (ad_reg == bd_reg);
        end
        if (state_reg == rasmr_pkg::FR_MUL2)
        begin
            p2_reg  <= prod;
            err_reg <= (ad_reg == '0) || (bd_reg == '0);
            if (op_reg[1])
                den_reg <= prod;
            else if (eq_reg)
                den_reg <= ad_reg;
            else
                den_reg <= W'($signed(ad_reg[31:0]) * $signed(bd_reg[31:0]));
        end
    end
endmodule

>>> sv/rasmr_queue.sv
// Two-entry queue between front and back ends.
// Depends on rasmr_pkg.
module rasmr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rasmr_pkg::raw_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            nonempty,
    output rasmr_pkg::raw_t pop_data
);
    rasmr_pkg::raw_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= push_data;
    end

    // advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) full |-> !push || pop;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> nonempty)
        else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
endmodule

>>> sv/rasmr_back.sv
// Back end: binary gcd of magnitudes, then restoring division of each by the gcd.
// Error, equal or zero terms skip both. Depends on rasmr_pkg and rasmr_if.
module rasmr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            nonempty,
    input  rasmr_pkg::raw_t pop_data,
    output logic            pop,
    rasmr_res_if.source     res
);
    localparam int W = rasmr_pkg::RES_W;
    localparam int CW = $clog2(W + 1);

    rasmr_pkg::bk_state_t state_reg, state_next;
    logic [W-1:0] x_reg, y_reg, g_reg;
    logic [CW-1:0] sh_reg;
    logic [W-1:0] q_reg, r_reg, d_reg;
    logic [CW-1:0] cnt_reg;
    logic         nneg_reg, dneg_reg;
    logic [W-1:0] num_reg, den_reg, mn_reg, md_reg;
    logic         st_reg;
    logic [W:0]   trial;
    logic [W-1:0] rsh, diff;

    assign pop        = (state_reg == rasmr_pkg::BK_IDLE) && nonempty;
    assign res.valid  = (state_reg == rasmr_pkg::BK_DONE);
    assign res.res_num = num_reg;
    assign res.res_den = den_reg;
    assign res.status  = st_reg;

    assign rsh   = {r_reg[W-2:0], q_reg[W-1]};
    assign trial = {1'b0, rsh} - {1'b0, d_reg};
    assign diff  = (x_reg > y_reg) ? x_reg - y_reg : y_reg - x_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rasmr_pkg::BK_IDLE:
                if (nonempty)
                begin
                    if (pop_data.err || pop_data.num == pop_data.den ||
                        pop_data.num == '0 || pop_data.den == '0)
                        state_next = rasmr_pkg::BK_DONE;
                    else
                        state_next = rasmr_pkg::BK_GCD;
                end
            rasmr_pkg::BK_GCD:
                if (y_reg == '0) state_next = rasmr_pkg::BK_DIVN;
            rasmr_pkg::BK_DIVN:
                if (cnt_reg == CW'(W)) state_next = rasmr_pkg::BK_DIVD;
            rasmr_pkg::BK_DIVD:
                if (cnt_reg == CW'(W)) state_next = rasmr_pkg::BK_DONE;
            rasmr_pkg::BK_DONE:
                if (res.ready) state_next = rasmr_pkg::BK_IDLE;
            default: state_next = rasmr_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rasmr_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath: binary gcd one step a cycle, division one bit a cycle
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rasmr_pkg::BK_IDLE:
            begin
                if (pop_data.err)
                begin
                    num_reg <= '0;
                    den_reg <= '0;
                end
                else if (pop_data.num == pop_data.den)
                begin
                    num_reg <= W'(1);
                    den_reg <= W'(1);
                end
                else
                begin
                    num_reg <= pop_data.num;
                    den_reg <= pop_data.den;
                end
                st_reg   <= pop_data.err;
                nneg_reg <= pop_data.num[W-1];
                dneg_reg <= pop_data.den[W-1];
                mn_reg   <= pop_data.num[W-1] ? -pop_data.num : pop_data.num;
                md_reg   <= pop_data.den[W-1] ? -pop_data.den : pop_data.den;
                x_reg    <= pop_data.num[W-1] ? -pop_data.num : pop_data.num;
                y_reg    <= pop_data.den[W-1] ? -pop_data.den : pop_data.den;
                sh_reg   <= '0;
            end
            rasmr_pkg::BK_GCD:
            begin
                if (y_reg == '0)
                begin
                    g_reg   <= x_reg << sh_reg;
                    d_reg   <= x_reg << sh_reg;
                    q_reg   <= mn_reg;
                    r_reg   <= '0;
                    cnt_reg <= '0;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg  <= x_reg >> 1;
                    y_reg  <= y_reg >> 1;
                    sh_reg <= sh_reg + CW'(1);
                end
                else if (!x_reg[0])
                    x_reg <= x_reg >> 1;
                else if (!y_reg[0])
                    y_reg <= y_reg >> 1;
                else
                begin
                    x_reg <= (x_reg < y_reg) ? x_reg : y_reg;
                    y_reg <= diff >> 1;
                end
            end
            rasmr_pkg::BK_DIVN, rasmr_pkg::BK_DIVD:
            begin
                if (cnt_reg == CW'(W))
                begin
                    if (state_reg == rasmr_pkg::BK_DIVN)
                    begin
                        num_reg <= nneg_reg ? -q_reg : q_reg;
                        q_reg   <= md_reg;
                        r_reg   <= '0;
                        cnt_reg <= '0;
                    end
                    else
                        den_reg <= dneg_reg ? -q_reg : q_reg;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (!trial[W])
                    begin
                        r_reg <= trial[W-1:0];
                        q_reg <= {q_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= rsh;
                        q_reg <= {q_reg[W-2:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rasmr_pkg::BK_DIVN && cnt_reg == '0) |-> g_reg != '0)
        else $error("zero gcd");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid && $stable(num_reg) && $stable(den_reg))
        else $error("result changed while stalled");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && st_reg) |-> num_reg == '0 && den_reg == '0)
        else $error("error result not zero");
endmodule

>>> test/tb_rational_add_sub_mul_reduce.sv
// Testbench for rational_add_sub_mul_reduce: directed table then random fractions,
// every result checked against a table expectation or a built-in fraction reducer.
// Depends on rasmr_pkg, rasmr_if and the block's RTL.
`timescale 1ns / 100ps

module tb_rational_add_sub_mul_reduce;

    typedef struct {
        rasmr_pkg::op_t op;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
        bit          fixed;
        logic [63:0] e_num;
        logic [63:0] e_den;
        logic        e_status;
    } row_t;

    typedef struct {
        logic [63:0] num;
        logic [63:0] den;
        logic        status;
    } frac_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    rasmr_req_if req ();
    rasmr_res_if res ();

    rational_add_sub_mul_reduce i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .res   (res.source)
    );

    frac_t pending_fracs[$];
    int    n_errors = 0;
    int    n_results = 0;
    int    n_sent = 0;
    bit    calm = 1'b0;
    bit    sender_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Magnitude of a two's complement 64-bit pattern
    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    // Divide keeping the sign of the dividend
    function automatic logic [63:0] shrink(input logic [63:0] v, input logic [63:0] g);
        logic [63:0] q;
        q = mag64(v) / g;
        return v[63] ? 64'd0 - q : q;
    endfunction

    // Form the result fraction (cross-multiplying where needed) and reduce to lowest terms
    function automatic frac_t reduce_fraction(input rasmr_pkg::op_t op,
            input logic [31:0] an_i, input logic [31:0] ad_i, input logic [31:0] bn_i,
            input logic [31:0] bd_i);
        frac_t r;
        logic [63:0] an, ad, bn, bd, num, den, lft, rgt, x, y, t;
        an = {{32{an_i[31]}}, an_i};
        ad = {{32{ad_i[31]}}, ad_i};
        bn = {{32{bn_i[31]}}, bn_i};
        bd = {{32{bd_i[31]}}, bd_i};
        r.status = 1'b0;
        if (ad == 0 || bd == 0)
        begin
            r.num = '0;
            r.den = '0;
            r.status = 1'b1;
            return r;
        end
        if (op == rasmr_pkg::OP_MUL || op == rasmr_pkg::OP_MUL_ALT)
        begin
            num = an * bn;
            den = ad * bd;
        end
        else if (ad == bd)
        begin
            num = (op == rasmr_pkg::OP_SUB) ? an - bn : an + bn;
            den = ad;
        end
        else
        begin
            lft = an * bd;
            rgt = ad * bn;
            num = (op == rasmr_pkg::OP_SUB) ? lft - rgt : lft + rgt;
            den = ad * bd;
        end
        if (num == den)
        begin
            num = 64'd1;
            den = 64'd1;
        end
        else if (num != 0 && den != 0)
        begin
            x = mag64(num);
            y = mag64(den);
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            if (x > 1)
            begin
                num = shrink(num, x);
                den = shrink(den, x);
            end
        end
        r.num = num;
        r.den = den;
        return r;
    endfunction

    // Offer one item, hold until transferred, record its expected result
    task automatic send_item(input row_t rw);
        frac_t f;
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= rw.op;
        req.a_num <= rw.an;
        req.a_den <= rw.ad;
        req.b_num <= rw.bn;
        req.b_den <= rw.bd;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        if (rw.fixed)
        begin
            f.num = rw.e_num;
            f.den = rw.e_den;
            f.status = rw.e_status;
        end
        else
        begin
            f = reduce_fraction(rw.op, rw.an, rw.ad, rw.bn, rw.bd);
        end
        pending_fracs.push_back(f);
        n_sent++;
    endtask

    function automatic row_t mk(input rasmr_pkg::op_t op, input logic [31:0] an,
            input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd);
        row_t rw;
        rw.op = op;
        rw.an = an;
        rw.ad = ad;
        rw.bn = bn;
        rw.bd = bd;
        rw.fixed = 1'b0;
        rw.e_num = '0;
        rw.e_den = '0;
        rw.e_status = 1'b0;
        return rw;
    endfunction

    function automatic row_t mkx(input row_t rw, input logic [63:0] n, input logic [63:0] d,
            input logic s);
        row_t o;
        o = rw;
        o.fixed = 1'b1;
        o.e_num = n;
        o.e_den = d;
        o.e_status = s;
        return o;
    endfunction

    // Random operand: mostly small, sometimes full range or edge patterns
    function automatic logic [31:0] rnd_operand();
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom_range(0, 40) - 20;
            3: return $urandom_range(0, 2000) - 1000;
            4: return $urandom();
            default: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                           ^ $urandom_range(0, 1);
        endcase
    endfunction

    // Result side: random stalls, compare each transfer with the oldest expectation
    initial
    begin
        frac_t e;
        int gap;
        res.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                n_results++;
                if (pending_fracs.size() == 0)
                begin
                    $display("%0t: unexpected result %h/%h status %b", $time,
                             res.res_num, res.res_den, res.status);
                    n_errors++;
                end
                else
                begin
                    e = pending_fracs.pop_front();
                    if (res.res_num !== e.num || res.res_den !== e.den
                            || res.status !== e.status)
                    begin
                        $display("%0t: mismatch expected %h/%h status %b, actual %h/%h status %b",
                                 $time, e.num, e.den, e.status,
                                 res.res_num, res.res_den, res.status);
                        n_errors++;
                    end
                end
            end
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                res.ready <= 1'b0;
                gap = $urandom_range(1, 9);
                repeat (gap) @(posedge clk);
                res.ready <= 1'b1;
            end
            else
            begin
                res.ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial
    begin
        row_t tbl[$];
        row_t rw;
        int k;
        req.valid = 1'b0;
        req.req_type = rasmr_pkg::OP_ADD;
        req.a_num = '0;
        req.a_den = 32'd1;
        req.b_num = '0;
        req.b_den = 32'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tbl.push_back(mkx(mk(rasmr_pkg::OP_ADD, 1, 0, 1, 1), 0, 0, 1'b1));
        tbl.push_back(mkx(mk(rasmr_pkg::OP_MUL, 5, 3, 7, 0), 0, 0, 1'b1));
        tbl.push_back(mkx(mk(rasmr_pkg::OP_SUB, 0, 0, 0, 0), 0, 0, 1'b1));
        tbl.push_back(mkx(mk(rasmr_pkg::OP_ADD, 1, 2, 1, 2), 1, 1, 1'b0));
        tbl.push_back(mkx(mk(rasmr_pkg::OP_MUL, 3, 4, 4, 3), 1, 1, 1'b0));
        tbl.push_back(mkx(mk(rasmr_pkg::OP_SUB, 3, 5, 3, 5), 0, 5, 1'b0));
        tbl.push_back(mkx(mk(rasmr_pkg::OP_MUL, 0, 7, 9, 2), 0, 14, 1'b0));
        tbl.push_back(mk(rasmr_pkg::OP_SUB, 1, 2, 1, 3));
        tbl.push_back(mk(rasmr_pkg::OP_ADD, 1, 6, 1, 10));
        tbl.push_back(mk(rasmr_pkg::OP_MUL_ALT, 6, 9, 10, -4));
        tbl.push_back(mk(rasmr_pkg::OP_ADD, -3, 4, 5, -6));
        tbl.push_back(mk(rasmr_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        tbl.push_back(mk(rasmr_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1));
        tbl.push_back(mk(rasmr_pkg::OP_SUB, 32'h8000_0000, 3, 32'h7FFF_FFFF,
                         32'h8000_0000));
        tbl.push_back(mk(rasmr_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0001));
        tbl.push_back(mk(rasmr_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF));
        tbl.push_back(mk(rasmr_pkg::OP_SUB, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0001,
                         32'h7FFF_FFFF));
        tbl.push_back(mk(rasmr_pkg::OP_MUL, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                         32'h5555_5555));
        tbl.push_back(mk(rasmr_pkg::OP_ADD, 2, -4, 3, -4));
        foreach (tbl[i])
            send_item(tbl[i]);

        // Drain fully before carrying on
        req.valid <= 1'b0;
        wait (pending_fracs.size() == 0);
        @(posedge clk);

        for (k = 0; k < 530; k++)
        begin
            if (k == 250)
            begin
                req.valid <= 1'b0;
                wait (pending_fracs.size() == 0);
                @(posedge clk);
            end
            if (k == 450)
                calm = 1'b1;
            rw = mk(rasmr_pkg::op_t'($urandom_range(0, 3)), rnd_operand(), rnd_operand(),
                    rnd_operand(), rnd_operand());
            // Shared denominators often, to reach the direct path
            if ($urandom_range(0, 3) == 0)
                rw.bd = rw.ad;
            send_item(rw);
        end
        req.valid <= 1'b0;
        sender_done = 1'b1;
    end

    // End of run
    initial
    begin
        wait (sender_done);
        wait (pending_fracs.size() == 0);
        repeat (400) @(posedge clk);
        $display("Sent %0d fractions over all four operation codes, %0d results checked.",
                 n_sent, n_results);
        if (n_errors == 0 && pending_fracs.size() == 0)
            $display("rational_add_sub_mul_reduce test passed");
        else
            $display("rational_add_sub_mul_reduce test failed");
        $finish;
    end

    // Timeout
    initial
    begin
        #20ms;
        $display("rational_add_sub_mul_reduce test failed");
        $finish;
    end
endmodule

>>> rational_add_sub_mul_reduce.f
sv/rasmr_pkg.sv
sv/rasmr_if.sv
sv/rasmr_front.sv
sv/rasmr_queue.sv
sv/rasmr_back.sv
sv/rational_add_sub_mul_reduce.sv
test/tb_rational_add_sub_mul_reduce.sv
